// ===== sv/dispc_pkg.sv =====
// ----------------------------------------------------------------------------
// dispc_pkg: shared types and constants for the displacement rebuild check
// Field widths, arithmetic widths and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package dispc_pkg;

  // Stream payload
  localparam int COORD_W    = 24;
  localparam int NUM_COORD  = 6;
  localparam int S_TDATA_W  = COORD_W * NUM_COORD;
  localparam int M_TDATA_W  = 32;

  // Arithmetic
  localparam int DIFF_W     = COORD_W + 1;   // full-precision difference
  localparam int MAG_W      = DIFF_W;        // magnitude up to 2^24
  localparam int SQ_W       = 50;            // sum of three squares < 3*2^48
  localparam int BUF_W      = 16;
  localparam int BSQ_W      = 2 * BUF_W;
  localparam int CMP_W      = SQ_W + 2;      // r2 * 4 against buffer^2
  localparam int BUF_FRAC   = 12;
  localparam int OUT_FRAC   = 12;
  localparam logic [BUF_W-1:0] BUF_RESET = 16'd6144;  // 1.5 in Q4.12

  // Square root unit: one result bit per step
  localparam int ROOT_W     = 25;
  localparam int REM_W      = ROOT_W + 1;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_STEPS - 1);

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture coordinate differences
    logic square;     // square the three differences, latch threshold
    logic sum;        // add the squares
    logic update;     // running max and threshold check
    logic root_init;  // load radicand, clear root
    logic root_step;  // one digit of the root
    logic load_out;   // fill output register, clear set state
  } dispc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;       // current item closes the set
  } dispc_stat_t;

endpackage

// ===== sv/dispc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dispc_ctrl: sequencer for the displacement rebuild check
// Walks one item through square, sum and update; on the last item of a set
// runs the bit-serial root and hands the result to the output register.
// ----------------------------------------------------------------------------
module dispc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  dispc_pkg::dispc_stat_t stat_i,
  output dispc_pkg::dispc_cmd_t  cmd_o
);
  import dispc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_UPDATE,
    ST_PREP,
    ST_ROOT,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              valid_q, valid_d;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    valid_d = valid_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = stat_i.last ? ST_PREP : ST_IDLE;
      end
      ST_PREP: begin
        cmd_o.root_init = 1'b1;
        step_d          = '0;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        step_d          = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for a free output register
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          valid_d        = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;

endmodule

// ===== sv/dispc_dp.sv =====
// ----------------------------------------------------------------------------
// dispc_dp: datapath of the displacement rebuild check
// Differences, squares, running maximum, threshold compare, restoring root.
// ----------------------------------------------------------------------------
module dispc_dp #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dispc_pkg::BUF_W-1:0]      cfg_wdata_i,
  input  logic [dispc_pkg::S_TDATA_W-1:0]  in_data_i,
  input  logic                             in_last_i,
  input  dispc_pkg::dispc_cmd_t            cmd_i,
  output dispc_pkg::dispc_stat_t           stat_o,
  output logic [dispc_pkg::M_TDATA_W-1:0]  out_data_o
);
  import dispc_pkg::*;

  // Threshold and root rescaling shifts
  localparam int TSHL = (COORD_FRAC_BITS >= BUF_FRAC) ? 2 * (COORD_FRAC_BITS - BUF_FRAC) : 0;
  localparam int TSHR = (COORD_FRAC_BITS >= BUF_FRAC) ? 0 : 2 * (BUF_FRAC - COORD_FRAC_BITS);
  localparam int RSHR = (COORD_FRAC_BITS >= OUT_FRAC) ? 2 * (COORD_FRAC_BITS - OUT_FRAC) : 0;
  localparam int RSHL = (COORD_FRAC_BITS >= OUT_FRAC) ? 0 : 2 * (OUT_FRAC - COORD_FRAC_BITS);

  // Control-like state
  logic [BUF_W-1:0] buf_q;
  logic [SQ_W-1:0]  max_q, max_d;
  logic             exc_q, exc_d;
  logic             last_q;

  // Payload
  logic [MAG_W-1:0]  mag_q [3];
  logic [2*MAG_W-1:0] sq_q [3];
  logic [CMP_W-1:0]  thr_q;
  logic [SQ_W-1:0]   r2_q;
  logic [SQ_W-1:0]   rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic              sat_q;
  logic [M_TDATA_W-1:0] out_q;

  logic [MAG_W-1:0]   mag_d [3];
  logic [BSQ_W-1:0]   bsq;
  logic [CMP_W-1:0]   thr_d;
  logic [SQ_W-1:0]    r2_d;
  logic [SQ_W-1:0]    rad_d;
  logic               sat_d;
  logic [REM_W+1:0]   rem_t;
  logic [REM_W+1:0]   trial;
  logic               take;
  logic [ROOT_W-1:0]  res_root;

  // Absolute differences straight from the request
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [DIFF_W-1:0] a;
      logic signed [DIFF_W-1:0] b;
      logic signed [DIFF_W-1:0] d;
      a = DIFF_W'($signed(in_data_i[i*COORD_W +: COORD_W]));
      b = DIFF_W'($signed(in_data_i[(i+3)*COORD_W +: COORD_W]));
      d = a - b;
      mag_d[i] = d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);
    end
  end

  // Threshold: buffer^2 aligned to the 2F fraction bits of r2 * 4
  assign bsq   = BSQ_W'(buf_q) * BSQ_W'(buf_q);
  assign thr_d = (CMP_W'(bsq) << TSHL) >> TSHR;

  assign r2_d = SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);

  // Running max and crossing flag
  always_comb begin
    max_d = max_q;
    exc_d = exc_q;
    if (cmd_i.update && !exc_q) begin
      if (r2_q > max_q) max_d = r2_q;
      if ({r2_q, 2'b00} > thr_q) exc_d = 1'b1;
    end
    if (cmd_i.load_out) begin
      max_d = '0;
      exc_d = 1'b0;
    end
  end

  // Radicand rescaled to Q24, saturation when it would not fit
  assign rad_d = (max_q >> RSHR) << RSHL;
  assign sat_d = ((max_q >> (SQ_W - RSHL)) != '0) && (RSHL != 0);

  // One restoring root digit
  assign rem_t = {rem_q, rad_q[SQ_W-1 -: 2]};
  assign trial = (REM_W+2)'({root_q, 2'b01});
  assign take  = (rem_t >= trial);

  assign res_root = sat_q ? '1 : root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= BUF_RESET;
      max_q <= '0;
      exc_q <= 1'b0;
    end else begin
      if (cfg_we_i) buf_q <= cfg_wdata_i;
      max_q <= max_d;
      exc_q <= exc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      for (int i = 0; i < 3; i++) mag_q[i] <= mag_d[i];
      last_q <= in_last_i;
    end
    if (cmd_i.square) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= mag_q[i] * mag_q[i];
      thr_q <= thr_d;
    end
    if (cmd_i.sum) r2_q <= r2_d;
    if (cmd_i.root_init) begin
      rad_q  <= rad_d;
      sat_q  <= sat_d;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= rad_q << 2;
      rem_q  <= take ? REM_W'(rem_t - trial) : REM_W'(rem_t);
      root_q <= {root_q[ROOT_W-2:0], take};
    end
    if (cmd_i.load_out) begin
      out_q <= M_TDATA_W'({res_root, exc_q});
    end
  end

  assign stat_o.last = last_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/displacement_rebuild_check.sv =====
// Sequence: an accepted item passes through the square, sum and update states;
//   on a last item the prep state, the bit-serial square root (one result bit
//   per cycle) and the finish state follow, and the result is loaded once the
//   output register is free, so a stalled output holds off the next accept.
// Items: one in flight at a time; the square/sum/update sequence is shared.
// Reset: rst_ni clears the running max and flag and sets buffer_distance to 1.5.
// ----------------------------------------------------------------------------
// displacement_rebuild_check: neighbor list rebuild decision
// Tracks the peak squared particle displacement of a set until a crossing and
// flags a rebuild when a particle moved more than half the buffer distance.
// ----------------------------------------------------------------------------
module displacement_rebuild_check #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: buffer_distance, unsigned Q4.12
  input  logic                            cfg_we_i,
  input  logic [dispc_pkg::BUF_W-1:0]     cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // ref_x, ref_y, ref_z, cur_x, cur_y, cur_z (24 bits each)
  input  logic [dispc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                            s_axis_tlast,   // last_particle
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // needs_update [0], max_displacement [25:1], zero [31:26]
  output logic [dispc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import dispc_pkg::*;

  dispc_cmd_t  cmd;
  dispc_stat_t stat;

  dispc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dispc_dp #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== sv/dispc_chk.sv =====
// ----------------------------------------------------------------------------
// dispc_chk: port-level checks for the displacement rebuild check
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module dispc_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dispc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import dispc_pkg::*;

  // One request in flight: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a request is in flight");

  // A new result comes only out of the root sequence, never from idle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a completed root sequence");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // Padding above the root stays zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:ROOT_W+1] == '0))
    else $error("nonzero padding in result");

endmodule

bind displacement_rebuild_check dispc_chk u_dispc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/displacement_rebuild_check_tb.sv =====
// ----------------------------------------------------------------------------
// displacement_rebuild_check_tb: self-checking bench for the rebuild check
// Streams particle position pairs into the block and predicts each end-of-set
// verdict (update flag, floor root of the peak squared displacement). Both
// stream sides idle at random, and the result side is held off once for a
// long stretch. Runs through several buffer distances, the extremes included.
// ----------------------------------------------------------------------------
module displacement_rebuild_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dispc_pkg::*;

  localparam int FRAC          = 12;       // coordinate fraction bits
  localparam int SETTLE_CYCLES = 40;       // idle cycles after the last verdict
  localparam int STALL_LIMIT   = 4000;     // cycles without any handshake
  localparam int HOLD_CYCLES   = 600;      // long result-side hold-off
  localparam int PHASE_ITEMS   = 160;
  localparam int CMIN          = -8388608;
  localparam int CMAX          = 8388607;
  localparam logic [24:0] DISP_MAX = 25'h1FFFFFF;

  typedef struct packed {
    logic                      last;
    logic signed [COORD_W-1:0] cur_z, cur_y, cur_x, ref_z, ref_y, ref_x;
  } particle_t;

  typedef struct {
    bit        flag;
    bit [24:0] disp;
  } verdict_t;

  // Tracks the running peak and crossing flag of the open set and queues the
  // verdict each closing particle produces.
  class rebuild_verdicts;
    verdict_t           awaited[$];
    bit [BUF_W-1:0]     buffer_q12 = BUF_RESET;
    longint unsigned    peak_sq    = 0;
    bit                 crossed    = 0;
    int                 bad_cnt    = 0;
    int                 shown      = 0;

    function longint unsigned axis_sq(logic signed [COORD_W-1:0] a,
                                      logic signed [COORD_W-1:0] b);
      longint d;
      d = a - b;
      if (d < 0) d = -d;
      return longint'(d) * longint'(d);
    endfunction

    // floor sqrt, one result bit at a time from the top
    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function bit [24:0] root_q12(longint unsigned x);
      longint unsigned r;
      int k;
      if (FRAC >= OUT_FRAC) begin
        k = 2 * (FRAC - OUT_FRAC);
        r = isqrt(x >> k);
      end else begin
        k = 2 * (OUT_FRAC - FRAC);
        if (x >= (64'd1 << (50 - k))) return DISP_MAX;
        r = isqrt(x << k);
      end
      return (r > DISP_MAX) ? DISP_MAX : r[24:0];
    endfunction

    function void add_particle(particle_t p);
      longint unsigned r2, bsq, lim;
      verdict_t v;
      // once crossed, the rest of the set is ignored
      if (!crossed) begin
        r2 = axis_sq(p.ref_x, p.cur_x) + axis_sq(p.ref_y, p.cur_y) +
             axis_sq(p.ref_z, p.cur_z);
        if (r2 > peak_sq) peak_sq = r2;
        bsq = longint'(buffer_q12) * longint'(buffer_q12);
        if (FRAC >= BUF_FRAC) lim = bsq << (2 * (FRAC - BUF_FRAC));
        else                  lim = bsq >> (2 * (BUF_FRAC - FRAC));
        if ((r2 << 2) > lim) crossed = 1;
      end
      if (p.last) begin
        v.flag = crossed;
        v.disp = root_q12(peak_sq);
        awaited.push_back(v);
        peak_sq = 0;
        crossed = 0;
      end
    endfunction

    function void check_verdict(logic [M_TDATA_W-1:0] word);
      verdict_t want;
      if (awaited.size() == 0) begin
        bad_cnt++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: tdata=%h", word);
        end
        return;
      end
      want = awaited.pop_front();
      if (word[0] !== want.flag || word[25:1] !== want.disp || word[31:26] !== 6'd0) begin
        bad_cnt++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: update exp %0d got %b, max_disp exp %0d got %0d, pad %b",
                   want.flag, word[0], want.disp, word[25:1], word[31:26]);
        end
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [BUF_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  rebuild_verdicts verdicts = new;
  bit hold_results = 0;
  int quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  displacement_rebuild_check #(
    .COORD_FRAC_BITS(FRAC)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // mostly short gaps, some none, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic particle_t mk(int rx, int ry, int rz, int cx, int cy, int cz,
                                   bit last);
    particle_t p;
    p.ref_x = COORD_W'(rx);
    p.ref_y = COORD_W'(ry);
    p.ref_z = COORD_W'(rz);
    p.cur_x = COORD_W'(cx);
    p.cur_y = COORD_W'(cy);
    p.cur_z = COORD_W'(cz);
    p.last  = last;
    return p;
  endfunction

  // current position within +-lim of the reference on every axis
  function automatic particle_t near_particle(int lim, bit last);
    int span, rx, ry, rz;
    span = 8388608 - 262144;
    rx = int'($urandom_range(0, 2 * span)) - span;
    ry = int'($urandom_range(0, 2 * span)) - span;
    rz = int'($urandom_range(0, 2 * span)) - span;
    return mk(rx, ry, rz,
              rx + int'($urandom_range(0, 2 * lim)) - lim,
              ry + int'($urandom_range(0, 2 * lim)) - lim,
              rz + int'($urandom_range(0, 2 * lim)) - lim, last);
  endfunction

  function automatic particle_t noise_particle(bit last);
    return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, last);
  endfunction

  // Call right after a rising edge; returns at the edge that takes the request.
  task automatic send_particle(particle_t p, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {p.cur_z, p.cur_y, p.cur_x, p.ref_z, p.ref_y, p.ref_x};
    s_axis_tlast  <= p.last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    verdicts.add_particle(p);
  endtask

  // wait until every verdict is back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdicts.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_buffer(logic [BUF_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    verdicts.buffer_q12 = val;
  endtask

  // random sets sized around the current half-buffer threshold
  task automatic run_sets(int n_items);
    int sent, set_len, lim, r;
    bit steady;
    particle_t p;
    sent = 0;
    lim  = int'(verdicts.buffer_q12) * 3 / 8 + 1;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      set_len = (r < 70) ? $urandom_range(1, 8) : (r < 90) ? $urandom_range(9, 30) : 1;
      steady  = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 12)      p = noise_particle(i == set_len - 1);
        else if (r < 22) p = near_particle(lim * 3 + 1, i == set_len - 1);
        else             p = near_particle(lim, i == set_len - 1);
        send_particle(p, steady ? 0 : pick_gap());
      end
      sent += set_len;
    end
    drain();
  endtask

  // result side: random ready pattern plus one requested long hold-off
  initial begin : result_sink
    int hold_left, run_left, gap;
    hold_left = 0;
    run_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) verdicts.check_verdict(m_axis_tdata);
      if (hold_results) begin
        hold_results = 0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else if (m_axis_tready) begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          run_left = gap - 1;
        end else begin
          run_left = $urandom_range(0, 12);
        end
      end else begin
        m_axis_tready <= 1'b1;
        run_left = $urandom_range(0, 20);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [BUF_W-1:0] mid_buf;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset buffer 1.5: no motion, full-scale swings both ways, mixed extremes
    send_particle(mk(0, 0, 0, 0, 0, 0, 1), 0);
    send_particle(mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1), 0);
    send_particle(mk(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1), 1);
    send_particle(mk(CMAX, CMIN, 0, CMIN, CMAX, -1, 1), 0);
    // exactly half the buffer does not cross, one more unit does
    send_particle(mk(0, 0, 0, 3072, 0, 0, 1), 0);
    send_particle(mk(0, 0, 0, -3073, 0, 0, 1), 2);
    // crossing item still sets the peak, the bigger one after it is ignored
    send_particle(mk(0, 0, 0, 100, 0, 0, 0), 0);
    send_particle(mk(0, 0, 0, 5000, 0, 0, 0), 0);
    send_particle(mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0), 0);
    send_particle(mk(0, 0, 0, 7, 0, 0, 1), 0);
    // peak in the middle of a set, no crossing
    send_particle(mk(0, 0, 0, 10, 20, 30, 0), 0);
    send_particle(mk(1000, -1000, 500, 0, 0, 0, 0), 3);
    send_particle(mk(5, 5, 5, 0, 0, 0, 1), 0);
    // crossing on the closing item itself, alternating bit patterns
    send_particle(mk(-2000, -2000, -2000, 2000, 2000, 2000, 1), 0);
    send_particle(mk(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                     24'hAAAAAA, 1), 0);
    drain();

    // zero buffer: any motion crosses, none does not
    write_buffer('0);
    send_particle(mk(0, 0, 0, 0, 0, 0, 1), 0);
    send_particle(mk(0, 0, 0, 0, 1, 0, 1), 0);
    drain();

    // full buffer: threshold sits between 32767 and 32768
    write_buffer('1);
    send_particle(mk(0, 0, 0, 32767, 0, 0, 1), 0);
    send_particle(mk(0, 0, 0, 0, 0, 32768, 1), 0);
    drain();

    // random phases over several buffer settings
    write_buffer(BUF_RESET);
    run_sets(PHASE_ITEMS);
    write_buffer(16'd1);
    run_sets(PHASE_ITEMS);

    // hold results off while closing items keep coming
    hold_results = 1;
    for (int i = 0; i < 40; i++) send_particle(near_particle(4000, 1), 0);
    drain();

    write_buffer('1);
    run_sets(PHASE_ITEMS);
    write_buffer('0);
    run_sets(PHASE_ITEMS);
    for (int n = 0; n < 3; n++) begin
      mid_buf = BUF_W'($urandom);
      write_buffer(mid_buf);
      run_sets(PHASE_ITEMS);
    end
    write_buffer(16'd20000);
    run_sets(PHASE_ITEMS);

    if (verdicts.bad_cnt == 0 && verdicts.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
